FILE: sv/nkc_pkg.sv
// Package for the normalized kernel convolution block.
// Shared types, item kinds, status codes and default sizes; no dependencies.
package nkc_pkg;
  localparam int DefMaxWidth  = 256;
  localparam int DefMaxHeight = 256;
  localparam int DefMaxKernel = 7;

  typedef enum logic [1:0] {
    KIND_WEIGHT = 2'd0,
    KIND_PIXEL  = 2'd1,
    KIND_FILTER = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_BAD  = 2'd1,
    ST_ZERO = 2'd2,
    ST_EVEN = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_KSIZE  = 2'd2,
    REG_BAD    = 2'd3
  } reg_t;
endpackage

FILE: sv/nkc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module nkc_ram #(
  parameter int Width = 16,
  parameter int Depth = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: sv/nkc_divider.sv
// Restoring divider for the rounded weighted mean: floor(num / den), den > 0.
// One quotient bit per cycle; depends on nothing else.
module nkc_divider #(
  parameter int NumW = 56,
  parameter int DenW = 26
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic signed [NumW-1:0] num,
  input  logic [DenW-1:0]        den,
  output logic                   done,
  output logic signed [NumW-1:0] quot
);
  localparam int CntW = $clog2(NumW + 1);

  logic            busy;
  logic [CntW-1:0] cnt;
  logic [NumW-1:0] q;
  logic [DenW:0]   rem;
  logic [DenW-1:0] d;
  logic            neg;
  logic [DenW:0]   trial;
  logic [DenW:0]   shifted;

  // magnitude split keeps the loop unsigned; negative results fixed at the end
  always_comb begin
    shifted = {rem[DenW-1:0], q[NumW-1]};
    trial   = shifted - {1'b0, d};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      // done rises together with the last quotient bit
      done <= busy && (cnt == CntW'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= CntW'(NumW);
        neg  <= num[NumW-1];
        q    <= num[NumW-1] ? NumW'(-num) : NumW'(num);
        rem  <= '0;
        d    <= den;
      end else if (busy) begin
        if (!trial[DenW]) begin
          rem <= trial;
          q   <= {q[NumW-2:0], 1'b1};
        end else begin
          rem <= shifted;
          q   <= {q[NumW-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CntW'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // floor for negatives: -(ceil(|n|/d))
  always_comb begin
    if (neg) begin
      quot = (rem != '0) ? -$signed(q) - NumW'(1) : -$signed(q);
    end else begin
      quot = $signed(q);
    end
  end

  // start sets busy; busy and done are never both set; done is never held
  assert property (@(posedge clk) disable iff (rst) start |=> busy)
    else $error("divider did not start");
  assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("divider done while busy");
  assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("divider done held");
endmodule

FILE: sv/normalized_kernel_convolution.sv
// Top level of the normalized kernel convolution block.
// Uses nkc_pkg, nkc_ram (frame and kernel stores) and nkc_divider.
//
// Usage:
//   Input channel (in_valid/in_stall, kind,row,col,value) carries items that
//   write a kernel weight, write a pixel, or request a filtered pixel.
//   Output channel (out_valid/out_stall) returns one item per filter request:
//   out_row, out_col, out_value, status. Writes give no output item.
//   Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) sets width,
//   height, kernel size and bad value; write only while the block is idle.
// Flow:
//   Weight and pixel writes leave the block idle. A filter request first sums
//   the kernel weights (one memory read per cycle), then walks the window (one
//   pixel read and one multiply a cycle), then checks the flags and, unless the
//   weight sum is zero or a window pixel is bad, runs the bit-serial divider.
//   No new item is taken until the result has been delivered. An even kernel
//   size answers right after the request.
// Reset:
//   Registers return to 256, 256, 3, -32768. The kernel store is cleared by a
//   sweep of all MaxKernel^2 entries after reset, during which no item is taken.
//   The frame store is not cleared. A stalled output holds its item and the
//   block takes no new input until it is delivered.
module normalized_kernel_convolution #(
  parameter int MaxWidth  = nkc_pkg::DefMaxWidth,
  parameter int MaxHeight = nkc_pkg::DefMaxHeight,
  parameter int MaxKernel = nkc_pkg::DefMaxKernel
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         kind,
  input  logic [7:0]         row,
  input  logic [7:0]         col,
  input  logic signed [15:0] value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_row,
  output logic [7:0]         out_col,
  output logic signed [15:0] out_value,
  output logic [1:0]         status,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);
  localparam int KDepth = MaxKernel * MaxKernel;
  localparam int KAw    = $clog2(KDepth + 1);
  localparam int CAw    = $clog2(MaxWidth);
  localparam int RAw    = $clog2(MaxHeight);
  localparam int FDepth = 2 ** (RAw + CAw);
  localparam int KIw    = $clog2(MaxKernel + 1);
  localparam int AccW   = 32 + KAw + 2;   // sum of products, with headroom
  localparam int WsW    = 16 + KAw + 1;   // weight sum
  localparam int NumW   = AccW + 2;

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_WSUM  = 7'b0000100,
    S_MAC   = 7'b0001000,
    S_DIV   = 7'b0010000,
    S_WAIT  = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t state;

  // configuration
  logic [8:0]         img_w, img_h;
  logic [2:0]         ksize;
  logic signed [15:0] bad_val;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      img_w   <= 9'd256;
      img_h   <= 9'd256;
      ksize   <= 3'd3;
      bad_val <= 16'sh8000;
    end else if (cfg_valid) begin
      case (cfg_index)
        nkc_pkg::REG_WIDTH:  img_w   <= cfg_data[8:0];
        nkc_pkg::REG_HEIGHT: img_h   <= cfg_data[8:0];
        nkc_pkg::REG_KSIZE:  ksize   <= cfg_data[2:0];
        nkc_pkg::REG_BAD:    bad_val <= cfg_data;
        default: ;
      endcase
    end
  end

  // saturated sizes
  logic [12:0] w_eff, h_eff;
  logic [3:0]  m_eff;
  always_comb begin
    w_eff = ({4'd0, img_w} > 13'(MaxWidth))  ? 13'(MaxWidth)  : {4'd0, img_w};
    h_eff = ({4'd0, img_h} > 13'(MaxHeight)) ? 13'(MaxHeight) : {4'd0, img_h};
    m_eff = ({1'b0, ksize} > 4'(MaxKernel))  ? 4'(MaxKernel)  : {1'b0, ksize};
  end

  // request registers
  logic [7:0] req_row, req_col;
  logic [KIw-1:0] ki, kj;
  logic [KIw-1:0] ki_next, kj_next;
  logic           rd_issue;         // tap addresses still being issued
  logic           rd_live, rd_in;   // a read issued last cycle, and inside the image
  logic [KAw-1:0] clr_cnt;
  logic signed [WsW-1:0]  wsum;
  logic signed [AccW-1:0] acc;
  logic                   bad;
  logic signed [31:0]     prod;
  logic                   prod_live;
  logic signed [15:0]     prod_pix;

  // kernel store
  logic                    k_we;
  logic [$clog2(KDepth)-1:0] k_waddr, k_raddr;
  logic [15:0]             k_wdata, k_rdata;
  // frame store
  logic                    f_we;
  logic [$clog2(FDepth)-1:0] f_raddr;
  logic [15:0]             f_rdata;

  nkc_ram #(.Width(16), .Depth(KDepth)) u_kram (
    .clk(clk), .we(k_we), .waddr(k_waddr), .wdata(k_wdata),
    .raddr(k_raddr), .rdata(k_rdata)
  );
  nkc_ram #(.Width(16), .Depth(FDepth)) u_fram (
    .clk(clk), .we(f_we),
    .waddr({RAw'(row), CAw'(col)}), .wdata(value),
    .raddr(f_raddr), .rdata(f_rdata)
  );

  logic accept;
  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;

  logic wr_ok_k, wr_ok_f;
  assign wr_ok_k = (row < 8'(MaxKernel)) && (col < 8'(MaxKernel));
  assign wr_ok_f = ({5'd0, row} < 13'(MaxHeight)) && ({5'd0, col} < 13'(MaxWidth));

  always_comb begin
    k_we    = 1'b0;
    k_waddr = '0;
    k_wdata = value;
    if (state == S_CLEAR) begin
      k_we    = 1'b1;
      k_waddr = clr_cnt[$clog2(KDepth)-1:0];
      k_wdata = '0;
    end else if (accept && kind == nkc_pkg::KIND_WEIGHT && wr_ok_k) begin
      k_we    = 1'b1;
      k_waddr = $bits(k_waddr)'(row * MaxKernel + col);
    end
    f_we = accept && kind == nkc_pkg::KIND_PIXEL && wr_ok_f;
  end

  // tap coordinates
  logic signed [13:0] tap_r, tap_c;
  logic               tap_in;
  always_comb begin
    tap_r  = $signed({6'd0, req_row}) + $signed(14'(ki)) - $signed(14'(m_eff >> 1));
    tap_c  = $signed({6'd0, req_col}) + $signed(14'(kj)) - $signed(14'(m_eff >> 1));
    tap_in = tap_r >= 0 && tap_r < $signed({1'b0, h_eff}) &&
             tap_c >= 0 && tap_c < $signed({1'b0, w_eff});
    k_raddr = $bits(k_raddr)'(ki * MaxKernel + kj);
    f_raddr = {tap_r[RAw-1:0], tap_c[CAw-1:0]};
  end

  logic last_tap;
  assign last_tap = (kj == KIw'(m_eff - 1)) && (ki == KIw'(m_eff - 1));

  // row-major walk over the active kernel corner
  always_comb begin
    if (kj == KIw'(m_eff - 1)) begin
      kj_next = '0;
      ki_next = ki + 1'b1;
    end else begin
      kj_next = kj + 1'b1;
      ki_next = ki;
    end
  end

  // divider: q = floor((2*acc + ws) / (2*ws)) with ws made positive
  logic signed [NumW-1:0] d_num;
  logic [WsW-1:0]         d_den;
  logic                   d_start, d_done;
  logic signed [NumW-1:0] d_quot;
  logic signed [AccW-1:0] acc_p;
  logic signed [WsW-1:0]  ws_p;
  always_comb begin
    acc_p = wsum[WsW-1] ? -acc : acc;
    ws_p  = wsum[WsW-1] ? -wsum : wsum;
    d_num = (NumW'(acc_p) <<< 1) + NumW'(ws_p);
    d_den = {ws_p[WsW-2:0], 1'b0};
  end

  assign d_start = (state == S_DIV) && (wsum != '0) && !bad;

  nkc_divider #(.NumW(NumW), .DenW(WsW)) u_div (
    .clk(clk), .rst(rst), .start(d_start), .num(d_num), .den(d_den),
    .done(d_done), .quot(d_quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_cnt   <= '0;
      out_valid <= 1'b0;
      rd_issue  <= 1'b0;
      rd_live   <= 1'b0;
      prod_live <= 1'b0;
    end else begin
      case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == KAw'(KDepth - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (accept && kind == nkc_pkg::KIND_FILTER) begin
            req_row <= row;
            req_col <= col;
            ki <= '0;
            kj <= '0;
            wsum <= '0;
            acc  <= '0;
            bad  <= 1'b0;
            rd_issue  <= 1'b1;
            rd_live   <= 1'b0;
            prod_live <= 1'b0;
            if (!m_eff[0]) begin
              // even size (zero too): no sums needed
              out_row   <= row;
              out_col   <= col;
              out_value <= bad_val;
              status    <= nkc_pkg::ST_EVEN;
              out_valid <= 1'b1;
              state     <= S_OUT;
            end else begin
              state <= S_WSUM;
            end
          end
        end
        S_WSUM: begin
          // one weight read per cycle, added when its data lands
          rd_live <= rd_issue;
          if (rd_live) wsum <= wsum + WsW'($signed(k_rdata));
          if (rd_issue) begin
            if (last_tap) begin
              rd_issue <= 1'b0;
            end else begin
              ki <= ki_next;
              kj <= kj_next;
            end
          end else if (rd_live) begin
            // last weight added at this edge
            ki       <= '0;
            kj       <= '0;
            rd_issue <= 1'b1;
            state    <= S_MAC;
          end
        end
        S_MAC: begin
          // stage 1: memory read; stage 2: multiply; stage 3: accumulate
          rd_live   <= rd_issue;
          rd_in     <= tap_in;
          prod_live <= rd_live && rd_in;
          prod      <= $signed(k_rdata) * $signed(f_rdata);
          prod_pix  <= f_rdata;
          if (prod_live) begin
            acc <= acc + AccW'(prod);
            if (prod_pix == bad_val) bad <= 1'b1;
          end
          if (rd_issue) begin
            if (last_tap) begin
              rd_issue <= 1'b0;
            end else begin
              ki <= ki_next;
              kj <= kj_next;
            end
          end else if (!rd_live) begin
            // last product, if any, is accumulated at this edge
            state <= S_DIV;
          end
        end
        S_DIV: begin
          out_row <= req_row;
          out_col <= req_col;
          if (wsum == '0) begin
            out_value <= bad_val;
            status    <= nkc_pkg::ST_ZERO;
            out_valid <= 1'b1;
            state     <= S_OUT;
          end else if (bad) begin
            out_value <= bad_val;
            status    <= nkc_pkg::ST_BAD;
            out_valid <= 1'b1;
            state     <= S_OUT;
          end else begin
            state   <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (d_done) begin
            if (d_quot > NumW'(32767)) out_value <= 16'sh7FFF;
            else if (d_quot < -NumW'(32768)) out_value <= 16'sh8000;
            else out_value <= d_quot[15:0];
            status    <= nkc_pkg::ST_OK;
            out_valid <= 1'b1;
            state     <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) out_valid |-> state == S_OUT)
    else $error("output valid outside output state");
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid && $stable(out_value))
    else $error("stalled result changed");
  assert property (@(posedge clk) disable iff (rst) d_done |-> state == S_WAIT)
    else $error("divider finished with no request waiting");
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != nkc_pkg::ST_OK) |-> out_value == bad_val)
    else $error("flagged result without bad value");
endmodule

FILE: tb/sv/normalized_kernel_convolution_test.sv
// Testbench for normalized_kernel_convolution: weight, pixel and filter items
// checked against a built-in predictor. Depends on nkc_pkg and the block's RTL.
module normalized_kernel_convolution_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FrameW = nkc_pkg::DefMaxWidth;
  localparam int FrameH = nkc_pkg::DefMaxHeight;
  localparam int KMax   = nkc_pkg::DefMaxKernel;

  typedef struct {
    nkc_pkg::kind_t     kind;
    logic [7:0]         row;
    logic [7:0]         col;
    logic signed [15:0] value;
  } item_t;

  typedef struct {
    logic [7:0]         row;
    logic [7:0]         col;
    logic signed [15:0] value;
    nkc_pkg::status_t   status;
  } filt_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         kind = '0;
  logic [7:0]         row = '0;
  logic [7:0]         col = '0;
  logic signed [15:0] value = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [7:0]         out_row;
  logic [7:0]         out_col;
  logic signed [15:0] out_value;
  logic [1:0]         status;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [1:0]         cfg_index = '0;
  logic [15:0]        cfg_data = '0;

  // Predictor state: frame, kernel and register copies.
  logic [15:0] pixel_mem [FrameW*FrameH];
  logic [15:0] weight_mem [KMax*KMax];
  logic [8:0]  img_w = 9'd256;
  logic [8:0]  img_h = 9'd256;
  logic [2:0]  ksize = 3'd3;
  logic [15:0] bad_px = 16'h8000;

  // Generator side: pixels already queued for writing, so no filter window
  // ever touches a frame entry that was never written.
  bit          px_planned [FrameW*FrameH];

  item_t pending_items[$];
  filt_t expected_pixels[$];
  item_t cur_item;
  int    mismatches = 0;
  int    items_sent = 0;
  longint cycle_cnt = 0;

  normalized_kernel_convolution dut (.*);

  always #5 clk = ~clk;

  always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

  // Random idling with a 10 percent chance, none in a recurring calm stretch.
  function automatic bit idle_now();
    if ((cycle_cnt % 20000) < 5000) return 1'b0;
    return $urandom_range(0, 99) < 10;
  endfunction

  // Weighted mean over the window, with the status priority even size,
  // zero weight sum, then bad pixel.
  function automatic filt_t filter_pixel(input logic [7:0] r0, input logic [7:0] c0);
    int     w, h, m, half, r, c;
    longint wsum, acc, num, den, q;
    bit     bad;
    filt_t  res;
    w = (img_w > FrameW) ? FrameW : img_w;
    h = (img_h > FrameH) ? FrameH : img_h;
    m = (ksize > KMax) ? KMax : ksize;
    half = m / 2;
    wsum = 0;
    acc = 0;
    bad = 1'b0;
    res.row = r0;
    res.col = c0;
    res.value = bad_px;
    res.status = nkc_pkg::ST_OK;
    if (m % 2 == 0) begin
      res.status = nkc_pkg::ST_EVEN;
      return res;
    end
    for (int ki = 0; ki < m; ki++)
      for (int kj = 0; kj < m; kj++)
        wsum += $signed(weight_mem[ki*KMax+kj]);
    for (int ki = 0; ki < m; ki++) begin
      r = int'(r0) + ki - half;
      if (r < 0 || r >= h) continue;
      for (int kj = 0; kj < m; kj++) begin
        c = int'(c0) + kj - half;
        if (c < 0 || c >= w) continue;
        if (pixel_mem[r*FrameW+c] == bad_px) bad = 1'b1;
        acc += longint'($signed(weight_mem[ki*KMax+kj])) *
               longint'($signed(pixel_mem[r*FrameW+c]));
      end
    end
    if (wsum == 0) begin
      res.status = nkc_pkg::ST_ZERO;
    end else if (bad) begin
      res.status = nkc_pkg::ST_BAD;
    end else begin
      if (wsum < 0) begin
        wsum = -wsum;
        acc = -acc;
      end
      // round half up: floor((2*acc + wsum) / (2*wsum))
      num = 2 * acc + wsum;
      den = 2 * wsum;
      q = num / den;
      if (num % den != 0 && num < 0) q = q - 1;
      if (q > 32767) q = 32767;
      if (q < -32768) q = -32768;
      res.value = q[15:0];
    end
    return res;
  endfunction

  // Apply one accepted item to the predictor.
  task automatic take_item(input item_t it);
    case (it.kind)
      nkc_pkg::KIND_WEIGHT: begin
        if (it.row < KMax && it.col < KMax) weight_mem[it.row*KMax+it.col] = it.value;
      end
      nkc_pkg::KIND_PIXEL: pixel_mem[it.row*FrameW+it.col] = it.value;
      nkc_pkg::KIND_FILTER: expected_pixels.push_back(filter_pixel(it.row, it.col));
      default: ;
    endcase
  endtask

  // Driver: load the next item once the current one is taken.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) take_item(cur_item);
      if (pending_items.size() > 0 && !idle_now()) begin
        cur_item = pending_items.pop_front();
        kind  <= cur_item.kind;
        row   <= cur_item.row;
        col   <= cur_item.col;
        value <= cur_item.value;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: compare each taken result with the oldest expectation.
  always @(posedge clk) begin
    filt_t exp_px;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_pixels.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result row %0d col %0d value %0d status %0d",
                     out_row, out_col, out_value, status);
        end else begin
          exp_px = expected_pixels.pop_front();
          if (out_row !== exp_px.row || out_col !== exp_px.col ||
              out_value !== exp_px.value || status !== exp_px.status) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected (%0d,%0d) %0d st %0d, got (%0d,%0d) %0d st %0d",
                       exp_px.row, exp_px.col, exp_px.value, exp_px.status,
                       out_row, out_col, out_value, status);
          end
        end
      end
      out_stall <= idle_now();
    end
  end

  task automatic push_item(input nkc_pkg::kind_t k, input int r, input int c, input int v);
    item_t it;
    it.kind = k;
    it.row = r[7:0];
    it.col = c[7:0];
    it.value = v[15:0];
    if (k == nkc_pkg::KIND_PIXEL) px_planned[it.row*FrameW+it.col] = 1'b1;
    pending_items.push_back(it);
    items_sent++;
  endtask

  function automatic int rand_pixel();
    if ($urandom_range(0, 19) == 0) return int'(bad_px);
    return int'($urandom);
  endfunction

  // Queue writes for every in-image window pixel not yet written (odd sizes
  // only), then the filter request itself.
  task automatic push_filter(input int r0, input int c0);
    int w, h, m, half, r, c;
    w = (img_w > FrameW) ? FrameW : img_w;
    h = (img_h > FrameH) ? FrameH : img_h;
    m = (ksize > KMax) ? KMax : ksize;
    half = m / 2;
    if (m % 2 == 1) begin
      for (int ki = 0; ki < m; ki++) begin
        for (int kj = 0; kj < m; kj++) begin
          r = r0 + ki - half;
          c = c0 + kj - half;
          if (r >= 0 && r < h && c >= 0 && c < w && !px_planned[r*FrameW+c])
            push_item(nkc_pkg::KIND_PIXEL, r, c, rand_pixel());
        end
      end
    end
    push_item(nkc_pkg::KIND_FILTER, r0, c0, int'($urandom));
  endtask

  // Config writes happen only with the block idle.
  task automatic write_reg(input nkc_pkg::reg_t idx, input logic [15:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      nkc_pkg::REG_WIDTH:  img_w  = data[8:0];
      nkc_pkg::REG_HEIGHT: img_h  = data[8:0];
      nkc_pkg::REG_KSIZE:  ksize  = data[2:0];
      nkc_pkg::REG_BAD:    bad_px = data;
      default: ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  // Drain: all items taken, all results back, then an extra idle wait.
  task automatic drain();
    while (!(pending_items.size() == 0 && !in_valid && expected_pixels.size() == 0))
      @(posedge clk);
    repeat (250) @(posedge clk);
  endtask

  function automatic int pick_size();
    case ($urandom_range(0, 6))
      0: return 0;
      1: return 1;
      2: return 256;
      3: return 511;
      4: return $urandom_range(257, 510);
      default: return $urandom_range(2, 24);
    endcase
  endfunction

  // Row or column coordinate: mostly near the top/left or near the far
  // image edge, sometimes anywhere in the 8-bit range.
  function automatic int pick_coord(input int lim);
    int e;
    e = (lim > 256) ? 256 : lim;
    case ($urandom_range(0, 9))
      0: return $urandom_range(0, 255);
      1, 2, 3: return (e > 4) ? $urandom_range(e - 4, (e > 255) ? 255 : e) : $urandom_range(0, 4);
      default: return $urandom_range(0, 10);
    endcase
  endfunction

  initial begin
    int k, m;
    for (int i = 0; i < KMax*KMax; i++) weight_mem[i] = '0;
    for (int i = 0; i < FrameW*FrameH; i++) begin
      pixel_mem[i] = '0;
      px_planned[i] = 1'b0;
    end
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed part, reset registers: zero weight sum first.
    push_filter(0, 0);
    // Center weight 2: pixel values +3 and -3 through a single nonzero tap.
    push_item(nkc_pkg::KIND_WEIGHT, 1, 1, 2);
    push_item(nkc_pkg::KIND_PIXEL, 10, 10, 3);
    push_filter(10, 10);
    push_item(nkc_pkg::KIND_PIXEL, 10, 10, -3);
    push_filter(10, 10);
    // Negative weight sum.
    push_item(nkc_pkg::KIND_WEIGHT, 1, 1, -2);
    push_filter(10, 10);
    // Weight sum 1 with huge taps: clamp high, then clamp low.
    push_item(nkc_pkg::KIND_WEIGHT, 1, 1, 32767);
    push_item(nkc_pkg::KIND_WEIGHT, 1, 2, -32766);
    push_item(nkc_pkg::KIND_PIXEL, 20, 20, 32767);
    push_item(nkc_pkg::KIND_PIXEL, 20, 21, -32767);
    push_filter(20, 20);
    push_item(nkc_pkg::KIND_PIXEL, 20, 20, -32767);
    push_item(nkc_pkg::KIND_PIXEL, 20, 21, 32767);
    push_filter(20, 20);
    // Bad pixel in the window, then far corner with taps outside the image.
    push_item(nkc_pkg::KIND_PIXEL, 20, 19, -32768);
    push_filter(20, 20);
    push_filter(255, 255);
    // Weight writes outside the store and an unused kind.
    push_item(nkc_pkg::KIND_WEIGHT, 255, 0, 5);
    push_item(nkc_pkg::KIND_WEIGHT, 3, 200, 5);
    push_item(nkc_pkg::KIND_NONE, 255, 255, -1);
    drain();

    // Even kernel size, then size 1 with max bad value.
    write_reg(nkc_pkg::REG_KSIZE, 16'd4);
    push_filter(5, 5);
    drain();
    write_reg(nkc_pkg::REG_KSIZE, 16'd1);
    write_reg(nkc_pkg::REG_BAD, 16'h7FFF);
    write_reg(nkc_pkg::REG_WIDTH, 16'd1);
    write_reg(nkc_pkg::REG_HEIGHT, 16'd1);
    push_item(nkc_pkg::KIND_WEIGHT, 0, 0, 1);
    push_filter(0, 0);
    push_filter(3, 0);
    drain();

    // Random phases, each with its own register setting and an item budget.
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(nkc_pkg::REG_WIDTH, 16'(pick_size()) | (16'($urandom) & 16'hFE00));
      write_reg(nkc_pkg::REG_HEIGHT, 16'(pick_size()) | (16'($urandom) & 16'hFE00));
      write_reg(nkc_pkg::REG_KSIZE, (ph < 2) ? 16'd7 : 16'($urandom_range(0, 7)));
      case (ph % 3)
        0: write_reg(nkc_pkg::REG_BAD, 16'h8000);
        1: write_reg(nkc_pkg::REG_BAD, 16'h7FFF);
        default: write_reg(nkc_pkg::REG_BAD, 16'($urandom));
      endcase
      m = (ksize > KMax) ? KMax : ksize;
      // Fresh kernel in most phases: small weights, now and then full range.
      if ($urandom_range(0, 9) < 7) begin
        for (int ki = 0; ki < KMax; ki++)
          for (int kj = 0; kj < KMax; kj++)
            push_item(nkc_pkg::KIND_WEIGHT, ki, kj,
                      ($urandom_range(0, 9) == 0) ? int'($urandom) : $urandom_range(0, 12) - 4);
      end
      for (int n = 0; n < 120 && items_sent < 160 * (ph + 1); n++) begin
        k = $urandom_range(0, 99);
        if (k < 12) begin
          if ($urandom_range(0, 4) == 0)
            push_item(nkc_pkg::KIND_WEIGHT, $urandom_range(0, 255), $urandom_range(0, 255),
                      $urandom);
          else
            push_item(nkc_pkg::KIND_WEIGHT, $urandom_range(0, (m > 0) ? m - 1 : 0),
                      $urandom_range(0, (m > 0) ? m - 1 : 0), $urandom_range(0, 40) - 20);
        end else if (k < 25) begin
          push_item(nkc_pkg::KIND_PIXEL, pick_coord(img_h), pick_coord(img_w), rand_pixel());
        end else if (k < 28) begin
          push_item(nkc_pkg::KIND_NONE, $urandom_range(0, 255), $urandom_range(0, 255),
                    $urandom);
        end else begin
          push_filter(pick_coord(img_h), pick_coord(img_w));
        end
      end
      drain();
    end

    if (expected_pixels.size() != 0) mismatches++;
    if (mismatches == 0) begin
      $display("normalized_kernel_convolution_test OK");
    end else begin
      $display("normalized_kernel_convolution_test NOT OK");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("normalized_kernel_convolution_test NOT OK");
    $finish;
  end
endmodule
